// ----- sv/efra_pkg.sv -----
package efra_pkg;

	localparam int MAX_ROOMS = 16;
	localparam int ROOM_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
	localparam int IN_W = 32;
	localparam int TIME_W = 40;
	localparam int CNT_W = 32;
	localparam int NROOM_W = 5;
	localparam int OUT_IDX_W = 4;
	localparam int GRP = 4;
	localparam int GPOS_W = $clog2(GRP);
	localparam int NGRP = (MAX_ROOMS + GRP - 1) / GRP;
	localparam int NPAD = NGRP * GRP;

	localparam logic [NROOM_W-1:0] NUM_ROOMS_RST = NROOM_W'(16);
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef struct packed {
		logic [IN_W-1:0] start_time;
		logic [IN_W-1:0] stop_time;
	} job_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] room_index;
		logic [TIME_W-1:0] finish_time;
		logic was_delayed;
		logic [OUT_IDX_W-1:0] busiest_room;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PICK,
		ST_UPD,
		ST_MAX1,
		ST_MAX2
	} state_t;

	typedef struct packed {
		logic cap;
		logic pick;
		logic upd;
		logic max1;
		logic max2;
	} ctl_t;

	// Candidate a wins over candidate b when it has the smaller key; on equal keys
	// the one with the lower room number wins.
	function automatic logic beats(input logic av, input logic [TIME_W-1:0] ak,
		input logic bv, input logic [TIME_W-1:0] bk, input logic a_first);
		logic le;
		le = a_first ? (ak <= bk) : (ak < bk);
		return av && (!bv || le);
	endfunction

endpackage

// ----- sv/efra_ctrl.sv -----
module efra_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output efra_pkg::ctl_t ctl
);

	efra_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= efra_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		busy = 1'b1;
		unique case (state_q)
			efra_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.cap = 1'b1;
					state_d = efra_pkg::ST_PICK;
				end
			end
			efra_pkg::ST_PICK: begin
				ctl.pick = 1'b1;
				state_d = efra_pkg::ST_UPD;
			end
			efra_pkg::ST_UPD: begin
				ctl.upd = 1'b1;
				state_d = efra_pkg::ST_MAX1;
			end
			efra_pkg::ST_MAX1: begin
				ctl.max1 = 1'b1;
				state_d = efra_pkg::ST_MAX2;
			end
			efra_pkg::ST_MAX2: begin
				ctl.max2 = 1'b1;
				state_d = efra_pkg::ST_IDLE;
			end
			default: begin
				state_d = efra_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/efra_dp.sv -----
module efra_dp (
	input  logic clk,
	input  logic arst_n,
	input  efra_pkg::ctl_t ctl,
	input  efra_pkg::job_t job,
	input  logic cfg_we,
	input  logic [efra_pkg::NROOM_W-1:0] cfg_wdata,
	output efra_pkg::result_t result,
	output logic done
);

	logic [efra_pkg::NROOM_W-1:0] num_rooms_q;
	logic [efra_pkg::TIME_W-1:0] busy_until_q [efra_pkg::MAX_ROOMS];
	logic [efra_pkg::CNT_W-1:0] use_count_q [efra_pkg::MAX_ROOMS];

	logic [efra_pkg::MAX_ROOMS-1:0] active;
	logic [efra_pkg::MAX_ROOMS-1:0] free_d;
	logic [efra_pkg::MAX_ROOMS-1:0] free_q;

	logic [efra_pkg::IN_W-1:0] fin_direct_q;
	logic [efra_pkg::IN_W-1:0] dur_q;

	logic src_v [efra_pkg::NPAD];
	logic [efra_pkg::TIME_W-1:0] src_k [efra_pkg::NPAD];

	logic grp_v_d [efra_pkg::NGRP];
	logic [efra_pkg::TIME_W-1:0] grp_k_d [efra_pkg::NGRP];
	logic [efra_pkg::GPOS_W-1:0] grp_p_d [efra_pkg::NGRP];
	logic grp_v_q [efra_pkg::NGRP];
	logic [efra_pkg::TIME_W-1:0] grp_k_q [efra_pkg::NGRP];
	logic [efra_pkg::GPOS_W-1:0] grp_p_q [efra_pkg::NGRP];

	logic [efra_pkg::ROOM_W-1:0] win_idx;
	logic [efra_pkg::TIME_W-1:0] win_k;

	logic [efra_pkg::ROOM_W-1:0] first_free;
	logic [efra_pkg::ROOM_W-1:0] pick_q;
	logic delayed_q;
	logic [efra_pkg::TIME_W-1:0] minval_q;
	logic [efra_pkg::TIME_W:0] delayed_sum;
	logic [efra_pkg::TIME_W-1:0] finish;
	logic [efra_pkg::TIME_W-1:0] finish_q;

	efra_pkg::result_t result_q;
	logic done_q;

	always_comb begin
		for (int i = 0; i < efra_pkg::MAX_ROOMS; i++) begin
			active[i] = (i == 0) || (int'(num_rooms_q) > i);
			free_d[i] = active[i] &&
				(busy_until_q[i] <= efra_pkg::TIME_W'(job.start_time));
		end
	end

	// Keys for the shared tournament: end times while picking a room, inverted use counts
	// while looking for the busiest one, so that the smallest key always wins.
	always_comb begin
		for (int i = 0; i < efra_pkg::NPAD; i++) begin
			if (i < efra_pkg::MAX_ROOMS) begin
				src_v[i] = active[i];
				src_k[i] = ctl.max1 ? efra_pkg::TIME_W'(~use_count_q[i]) : busy_until_q[i];
			end else begin
				src_v[i] = 1'b0;
				src_k[i] = '0;
			end
		end
	end

	always_comb begin
		logic win;
		int ia;
		int ib;
		for (int g = 0; g < efra_pkg::NGRP; g++) begin
			grp_v_d[g] = 1'b0;
			grp_k_d[g] = src_k[g * efra_pkg::GRP];
			grp_p_d[g] = '0;
			for (int p = 0; p < efra_pkg::GRP; p++) begin
				ia = g * efra_pkg::GRP + p;
				win = src_v[ia];
				for (int q = 0; q < efra_pkg::GRP; q++) begin
					ib = g * efra_pkg::GRP + q;
					if (q != p) begin
						win = win && efra_pkg::beats(src_v[ia], src_k[ia],
							src_v[ib], src_k[ib], p < q);
					end
				end
				if (win) begin
					grp_v_d[g] = 1'b1;
					grp_k_d[g] = src_k[ia];
					grp_p_d[g] = efra_pkg::GPOS_W'(p);
				end
			end
		end
	end

	always_comb begin
		logic win;
		win_idx = '0;
		win_k = grp_k_q[0];
		for (int g = 0; g < efra_pkg::NGRP; g++) begin
			win = grp_v_q[g];
			for (int h = 0; h < efra_pkg::NGRP; h++) begin
				if (h != g) begin
					win = win && efra_pkg::beats(grp_v_q[g], grp_k_q[g],
						grp_v_q[h], grp_k_q[h], g < h);
				end
			end
			if (win) begin
				win_idx = efra_pkg::ROOM_W'(g * efra_pkg::GRP + int'(grp_p_q[g]));
				win_k = grp_k_q[g];
			end
		end
	end

	always_comb begin
		first_free = '0;
		for (int i = efra_pkg::MAX_ROOMS - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				first_free = efra_pkg::ROOM_W'(i);
			end
		end
	end

	assign delayed_sum = {1'b0, minval_q} + (efra_pkg::TIME_W + 1)'(dur_q);

	always_comb begin
		if (delayed_q) begin
			finish = delayed_sum[efra_pkg::TIME_W] ? efra_pkg::TIME_MAX :
				delayed_sum[efra_pkg::TIME_W-1:0];
		end else begin
			finish = efra_pkg::TIME_W'(fin_direct_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rooms_q <= efra_pkg::NUM_ROOMS_RST;
			for (int i = 0; i < efra_pkg::MAX_ROOMS; i++) begin
				busy_until_q[i] <= '0;
				use_count_q[i] <= '0;
			end
			done_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				num_rooms_q <= cfg_wdata;
			end
			if (ctl.upd) begin
				busy_until_q[pick_q] <= finish;
				if (use_count_q[pick_q] != efra_pkg::CNT_MAX) begin
					use_count_q[pick_q] <= use_count_q[pick_q] + efra_pkg::CNT_W'(1);
				end
			end
			done_q <= ctl.max2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			free_q <= free_d;
			if (job.stop_time > job.start_time) begin
				fin_direct_q <= job.stop_time;
				dur_q <= job.stop_time - job.start_time;
			end else begin
				fin_direct_q <= job.start_time;
				dur_q <= '0;
			end
		end
		if (ctl.cap || ctl.max1) begin
			grp_v_q <= grp_v_d;
			grp_k_q <= grp_k_d;
			grp_p_q <= grp_p_d;
		end
		if (ctl.pick) begin
			delayed_q <= !(|free_q);
			pick_q <= (|free_q) ? first_free : win_idx;
			minval_q <= win_k;
		end
		if (ctl.upd) begin
			finish_q <= finish;
		end
		if (ctl.max2) begin
			result_q.room_index <= efra_pkg::OUT_IDX_W'(pick_q);
			result_q.finish_time <= finish_q;
			result_q.was_delayed <= delayed_q;
			result_q.busiest_room <= efra_pkg::OUT_IDX_W'(win_idx);
		end
	end

	assign result = result_q;
	assign done = done_q;

endmodule

// ----- sv/earliest_free_room_allocator.sv -----
// Channel     Handshake          Payload
// job in      start, busy        job (start_time, stop_time)
// result out  done               result (room_index, finish_time, was_delayed, busiest_room)
// config      cfg_we             cfg_wdata (num_rooms)
//
// A word is taken when start is high and busy is low; its result appears on done, and the
// next word can be taken in that cycle, so a new word is not taken before the last one's result.
// The room search is a four-way tournament per group of rooms and one across groups,
// run once for end times and once for use counts.
// Reset clears all end times and use counts and sets num_rooms to 16; the receiver cannot stall.
module earliest_free_room_allocator (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  efra_pkg::job_t job,
	input  logic cfg_we,
	input  logic [efra_pkg::NROOM_W-1:0] cfg_wdata,
	output efra_pkg::result_t result,
	output logic done
);

	efra_pkg::ctl_t ctl;

	efra_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.ctl(ctl)
	);

	efra_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.job(job),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.result(result),
		.done(done)
	);

endmodule

// ----- tb/tb_earliest_free_room_allocator.sv -----
module tb_earliest_free_room_allocator;
	import efra_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int DRAIN_CYCLES = 20;
	localparam int PRINT_CAP = 40;

	typedef struct {
		logic is_cfg;
		job_t job;
		logic [NROOM_W-1:0] rooms;
	} plan_entry_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	job_t job;
	logic cfg_we;
	logic [NROOM_W-1:0] cfg_wdata;
	result_t result;
	logic done;

	earliest_free_room_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.job(job),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.result(result),
		.done(done)
	);

	plan_entry_t job_plan[$];
	result_t expected_allocs[$];

	logic [TIME_W-1:0] room_free_at[MAX_ROOMS];
	logic [CNT_W-1:0] room_uses[MAX_ROOMS];
	logic [NROOM_W-1:0] rooms_cfg;

	logic job_taken;
	int idle_cycles;
	int burst_left;
	int gap_left;
	int settle_left;
	int mismatch_count;
	int jobs_sent;
	int allocs_checked;
	int delayed_seen;
	int saturated_seen;
	int settings_used;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic result_t allocate_room(job_t j);
		result_t r;
		logic [TIME_W-1:0] dur;
		logic [TIME_W:0] sum;
		int n;
		int pick;
		int best;
		logic found;
		dur = (j.stop_time > j.start_time) ? TIME_W'(j.stop_time - j.start_time) : '0;
		n = (rooms_cfg == 0) ? 1 : ((rooms_cfg > MAX_ROOMS) ? MAX_ROOMS : int'(rooms_cfg));
		found = 1'b0;
		pick = 0;
		best = 0;
		for (int i = 0; i < MAX_ROOMS; i++) begin
			if (!found && i < n && room_free_at[i] <= TIME_W'(j.start_time)) begin
				pick = i;
				found = 1'b1;
			end
		end
		if (found) begin
			r.finish_time = TIME_W'(j.start_time) + dur;
		end else begin
			for (int i = 1; i < MAX_ROOMS; i++) begin
				if (i < n && room_free_at[i] < room_free_at[pick]) begin
					pick = i;
				end
			end
			sum = {1'b0, room_free_at[pick]} + {1'b0, dur};
			r.finish_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
		end
		room_free_at[pick] = r.finish_time;
		if (room_uses[pick] != CNT_MAX) begin
			room_uses[pick] = room_uses[pick] + CNT_W'(1);
		end
		for (int i = 1; i < MAX_ROOMS; i++) begin
			if (i < n && room_uses[i] > room_uses[best]) begin
				best = i;
			end
		end
		r.room_index = OUT_IDX_W'(pick);
		r.was_delayed = !found;
		r.busiest_room = OUT_IDX_W'(best);
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP) begin
			$display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want,
				allocs_checked);
		end
	endtask

	task automatic plan_rooms(input int value);
		plan_entry_t e;
		e.is_cfg = 1'b1;
		e.job = '0;
		e.rooms = NROOM_W'(value);
		job_plan.insert(job_plan.size(), e);
	endtask

	task automatic plan_job(input logic [IN_W-1:0] s, input logic [IN_W-1:0] f);
		plan_entry_t e;
		e.is_cfg = 1'b0;
		e.job.start_time = s;
		e.job.stop_time = f;
		e.rooms = '0;
		job_plan.insert(job_plan.size(), e);
	endtask

	// Driver: presents one word at a time, in bursts, and writes the room count only
	// once every outstanding result has been seen.
	always @(negedge clk) begin
		logic n_start;
		job_t n_job;
		logic n_we;
		logic [NROOM_W-1:0] n_wdata;
		n_start = start;
		n_job = job;
		n_we = 1'b0;
		n_wdata = cfg_wdata;
		if (!arst_n) begin
			n_start = 1'b0;
		end else if (!(start && !job_taken)) begin
			n_start = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (job_plan.size() > 0) begin
				if (job_plan[0].is_cfg) begin
					if (expected_allocs.size() == 0) begin
						if (settle_left > 0) begin
							settle_left--;
						end else begin
							n_we = 1'b1;
							n_wdata = job_plan[0].rooms;
							void'(job_plan.pop_front());
							settle_left = SETTLE_CYCLES;
						end
					end
				end else begin
					n_start = 1'b1;
					n_job = job_plan[0].job;
					void'(job_plan.pop_front());
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
					end
				end
			end
		end
		start <= n_start;
		job <= n_job;
		cfg_we <= n_we;
		cfg_wdata <= n_wdata;
	end

	// Monitor and predictor: results are checked before the word taken at the same edge
	// is predicted, since a result always belongs to an earlier word.
	always @(posedge clk) begin
		result_t want;
		logic moved;
		job_taken <= arst_n && start && !busy;
		if (arst_n) begin
			moved = 1'b0;
			if (done) begin
				moved = 1'b1;
				if (expected_allocs.size() == 0) begin
					flag_mismatch("unexpected result", 64'(result), 64'(0));
				end else begin
					want = expected_allocs.pop_front();
					if (result.room_index !== want.room_index)
						flag_mismatch("room_index", 64'(result.room_index),
							64'(want.room_index));
					if (result.finish_time !== want.finish_time)
						flag_mismatch("finish_time", 64'(result.finish_time),
							64'(want.finish_time));
					if (result.was_delayed !== want.was_delayed)
						flag_mismatch("was_delayed", 64'(result.was_delayed),
							64'(want.was_delayed));
					if (result.busiest_room !== want.busiest_room)
						flag_mismatch("busiest_room", 64'(result.busiest_room),
							64'(want.busiest_room));
					allocs_checked++;
				end
			end
			if (cfg_we) begin
				rooms_cfg = cfg_wdata;
			end
			if (start && !busy) begin
				moved = 1'b1;
				want = allocate_room(job);
				expected_allocs.insert(expected_allocs.size(), want);
				jobs_sent++;
				if (want.was_delayed) delayed_seen++;
				if (want.finish_time == TIME_MAX) saturated_seen++;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired with %0d results outstanding",
					expected_allocs.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int rooms_seq[8];
		logic [IN_W-1:0] now_t;
		logic [IN_W-1:0] s;
		logic [IN_W-1:0] f;
		logic [IN_W:0] t_next;
		logic [63:0] g;
		logic [63:0] dmax;
		int n_act;
		int sh;
		int roll;
		int nr;

		start = 1'b0;
		job = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		job_taken = 1'b0;
		idle_cycles = 0;
		burst_left = 0;
		gap_left = 0;
		settle_left = SETTLE_CYCLES;
		mismatch_count = 0;
		jobs_sent = 0;
		allocs_checked = 0;
		delayed_seen = 0;
		saturated_seen = 0;
		settings_used = 0;
		rooms_cfg = NUM_ROOMS_RST;
		for (int i = 0; i < MAX_ROOMS; i++) begin
			room_free_at[i] = '0;
			room_uses[i] = '0;
		end

		// Directed: zero times, zero and negative durations, ties on end time and
		// on use count, and room counts of zero, one, and beyond the maximum.
		plan_job(0, 0);
		plan_job(0, 0);
		plan_job(0, 100);
		plan_job(0, 100);
		plan_job(10, 5);
		plan_rooms(2);
		plan_job(20, 50);
		plan_job(20, 50);
		plan_job(200, 200);
		plan_rooms(0);
		plan_job(200, 300);
		plan_job(250, 260);
		plan_rooms(31);
		plan_job(400, 500);
		plan_job(400, 500);
		plan_job(400, 500);
		plan_job(400, 500);
		plan_rooms(17);
		plan_job(450, 451);
		plan_job(460, 459);
		plan_rooms(1);
		plan_job(470, 480);
		plan_job(470, 480);
		plan_rooms(16);
		plan_job(600, 700);
		plan_job(600, 700);
		settings_used = 6;

		rooms_seq = '{1, 16, 0, 31, 17, 2, 5, 8};
		now_t = 1000;
		for (int phase = 0; phase < 12; phase++) begin
			nr = (phase < 8) ? rooms_seq[phase] : $urandom_range(0, 31);
			plan_rooms(nr);
			settings_used++;
			n_act = (nr == 0) ? 1 : ((nr > MAX_ROOMS) ? MAX_ROOMS : nr);
			sh = 2 + phase * 3;
			g = (sh >= 32) ? 64'hFFFF_FFFF : (64'd1 << sh);
			for (int k = 0; k < 130; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 4) begin
					s = $urandom_range(0, now_t);
					f = s + $urandom_range(0, 50);
				end else if (roll < 8) begin
					s = now_t;
					f = s - $urandom_range(0, 3);
				end else begin
					t_next = {1'b0, now_t} + $urandom_range(0, g[31:0]);
					now_t = t_next[IN_W] ? '1 : t_next[IN_W-1:0];
					s = now_t;
					case ($urandom_range(0, 2))
						0: dmax = g;
						1: dmax = g * n_act;
						default: dmax = g * n_act * 2;
					endcase
					if (dmax > 64'hFFFF_FFFF) dmax = 64'hFFFF_FFFF;
					t_next = {1'b0, s} + $urandom_range(1, dmax[31:0]);
					f = t_next[IN_W] ? '1 : t_next[IN_W-1:0];
				end
				plan_job(s, f);
			end
		end

		// One room and maximal durations push its end time into saturation.
		plan_rooms(1);
		settings_used++;
		for (int k = 0; k < 262; k++) begin
			plan_job($urandom_range(0, 15), '1);
		end
		plan_rooms(3);
		settings_used++;
		for (int k = 0; k < 6; k++) begin
			plan_job('1, $urandom);
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (job_plan.size() != 0 || start) @(posedge clk);
		while (expected_allocs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d of %0d jobs across %0d room-count settings.",
			allocs_checked, jobs_sent, settings_used);
		$display("%0d jobs were delayed and %0d finish times saturated; %0d mismatches.",
			delayed_seen, saturated_seen, mismatch_count);
		if (mismatch_count == 0 && expected_allocs.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/efra_pkg.sv
sv/efra_ctrl.sv
sv/efra_dp.sv
sv/earliest_free_room_allocator.sv
tb/tb_earliest_free_room_allocator.sv
